// ===== hw/rtl/jsu_pkg.sv =====
package jsu_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KindByte = 2'd0,
    KindDone = 2'd1,
    KindErr  = 2'd2
  } kind_e;

  // error codes
  localparam logic [3:0] ErrNoQuote    = 4'd0;
  localparam logic [3:0] ErrCtrlChar   = 4'd1;
  localparam logic [3:0] ErrBadEscape  = 4'd2;
  localparam logic [3:0] ErrBadHex     = 4'd3;
  localparam logic [3:0] ErrIncomplete = 4'd4;
  localparam logic [3:0] ErrNoLowSurr  = 4'd5;
  localparam logic [3:0] ErrLowRange   = 4'd6;
  localparam logic [3:0] ErrLoneLow    = 4'd7;
  localparam logic [3:0] ErrUnterm     = 4'd8;
  localparam logic [3:0] ErrNone       = 4'd0;

  // command queue sizing
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // encoded bytes of one code point, cnt is the byte count minus one
  typedef struct packed {
    logic [1:0]      cnt;
    logic [3:0][7:0] bytes;
  } utf8_t;

  // one queued command: all results caused by one input transaction
  typedef struct packed {
    kind_e           kind;
    logic [3:0]      code;
    logic [1:0]      cnt;
    logic [3:0][7:0] bytes;
  } cmd_t;

  // utf-8 encoding of a code point up to 0x10ffff
  function automatic utf8_t utf8_encode(logic [20:0] cp);
    utf8_t r;
    r.bytes = '0;
    if (cp <= 21'h7F) begin
      r.cnt      = 2'd0;
      r.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      r.cnt      = 2'd1;
      r.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
      r.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      r.cnt      = 2'd2;
      r.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
      r.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
      r.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
    end else begin
      r.cnt      = 2'd3;
      r.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
      r.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
      r.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
      r.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/jsu_front.sv =====
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          req_type_i,
  input  logic [7:0]    data_byte_i,
  input  logic          q_full_i,
  output logic          push_o,
  output jsu_pkg::cmd_t push_cmd_o
);
  import jsu_pkg::*;

  // decode phases
  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhStr    = 3'd1;
  localparam logic [2:0] PhEsc    = 3'd2;
  localparam logic [2:0] PhHexA   = 3'd3;
  localparam logic [2:0] PhSurrBs = 3'd4;
  localparam logic [2:0] PhSurrU  = 3'd5;
  localparam logic [2:0] PhHexB   = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  dcnt_q, dcnt_d;
  logic [9:0]  hi_q, hi_d;

  logic        accept;
  logic        has_res;
  cmd_t        cmd;
  logic [3:0]  hv;
  logic        hex_ok;
  logic [7:0]  hsub;
  logic [15:0] acc_new;
  logic [20:0] cp_pair;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // hex digit value
  always_comb begin
    hex_ok = 1'b1;
    hsub   = 8'h00;
    if (data_byte_i >= 8'h30 && data_byte_i <= 8'h39) begin
      hsub = data_byte_i - 8'h30;
    end else if (data_byte_i >= 8'h61 && data_byte_i <= 8'h66) begin
      hsub = data_byte_i - 8'h57;
    end else if (data_byte_i >= 8'h41 && data_byte_i <= 8'h46) begin
      hsub = data_byte_i - 8'h37;
    end else begin
      hex_ok = 1'b0;
    end
    hv = hsub[3:0];
  end

  assign acc_new = {acc_q[11:0], hv};
  // supplementary code point from the pending high half and the new low half
  assign cp_pair = {1'b0, hi_q, acc_new[9:0]} + 21'h10000;

  // phase machine and command build
  always_comb begin
    utf8_t u;
    phase_d = phase_q;
    acc_d   = acc_q;
    dcnt_d  = dcnt_q;
    hi_d    = hi_q;
    has_res = 1'b0;
    cmd     = '{kind: KindByte, code: ErrNone, cnt: 2'd0, bytes: '0};
    u       = '{cnt: 2'd0, bytes: '0};

    if (req_type_i) begin
      // end of text always reports an error and returns to idle
      has_res  = 1'b1;
      cmd.kind = KindErr;
      unique case (phase_q)
        PhStr:                  cmd.code = ErrUnterm;
        PhEsc, PhHexA, PhHexB:  cmd.code = ErrIncomplete;
        PhSurrBs, PhSurrU:      cmd.code = ErrNoLowSurr;
        default:                cmd.code = ErrNoQuote;
      endcase
    end else begin
      unique case (phase_q)
        PhStr: begin
          if (data_byte_i == 8'h22) begin
            has_res  = 1'b1;
            cmd.kind = KindDone;
          end else if (data_byte_i == 8'h5C) begin
            phase_d = PhEsc;
          end else if (data_byte_i < 8'h20) begin
            has_res  = 1'b1;
            cmd.kind = KindErr;
            cmd.code = ErrCtrlChar;
          end else begin
            has_res      = 1'b1;
            cmd.bytes[0] = data_byte_i;
          end
        end
        PhEsc: begin
          phase_d = PhStr;
          has_res = 1'b1;
          case (data_byte_i)
            8'h22, 8'h5C, 8'h2F: cmd.bytes[0] = data_byte_i;
            8'h62:               cmd.bytes[0] = 8'h08;
            8'h66:               cmd.bytes[0] = 8'h0C;
            8'h6E:               cmd.bytes[0] = 8'h0A;
            8'h72:               cmd.bytes[0] = 8'h0D;
            8'h74:               cmd.bytes[0] = 8'h09;
            8'h75: begin
              has_res = 1'b0;
              acc_d   = '0;
              dcnt_d  = '0;
              phase_d = PhHexA;
            end
            default: begin
              cmd.kind = KindErr;
              cmd.code = ErrBadEscape;
            end
          endcase
        end
        PhHexA, PhHexB: begin
          if (!hex_ok) begin
            has_res  = 1'b1;
            cmd.kind = KindErr;
            cmd.code = ErrBadHex;
          end else if (dcnt_q != 2'd3) begin
            acc_d  = acc_new;
            dcnt_d = dcnt_q + 2'd1;
          end else begin
            acc_d  = acc_new;
            dcnt_d = '0;
            if (phase_q == PhHexA) begin
              if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
                hi_d    = acc_new[9:0];
                phase_d = PhSurrBs;
              end else if (acc_new >= 16'hDC00 && acc_new <= 16'hDFFF) begin
                has_res  = 1'b1;
                cmd.kind = KindErr;
                cmd.code = ErrLoneLow;
              end else begin
                u            = utf8_encode({5'b00000, acc_new});
                has_res      = 1'b1;
                cmd.cnt      = u.cnt;
                cmd.bytes    = u.bytes;
                phase_d      = PhStr;
              end
            end else begin
              if (acc_new < 16'hDC00 || acc_new > 16'hDFFF) begin
                has_res  = 1'b1;
                cmd.kind = KindErr;
                cmd.code = ErrLowRange;
              end else begin
                u         = utf8_encode(cp_pair);
                has_res   = 1'b1;
                cmd.cnt   = u.cnt;
                cmd.bytes = u.bytes;
                acc_d     = '0;
                hi_d      = '0;
                phase_d   = PhStr;
              end
            end
          end
        end
        PhSurrBs: begin
          if (data_byte_i == 8'h5C) begin
            phase_d = PhSurrU;
          end else begin
            has_res  = 1'b1;
            cmd.kind = KindErr;
            cmd.code = ErrNoLowSurr;
          end
        end
        PhSurrU: begin
          if (data_byte_i == 8'h75) begin
            acc_d   = '0;
            dcnt_d  = '0;
            phase_d = PhHexB;
          end else begin
            has_res  = 1'b1;
            cmd.kind = KindErr;
            cmd.code = ErrNoLowSurr;
          end
        end
        default: begin
          // idle, and unused codes: wait for the opening quote
          if (data_byte_i == 8'h22) begin
            acc_d   = '0;
            dcnt_d  = '0;
            hi_d    = '0;
            phase_d = PhStr;
          end else begin
            has_res  = 1'b1;
            cmd.kind = KindErr;
            cmd.code = ErrNoQuote;
          end
        end
      endcase
    end

    // done and error both return to idle with cleared state
    if (has_res && cmd.kind != KindByte) begin
      phase_d = PhIdle;
      acc_d   = '0;
      dcnt_d  = '0;
      hi_d    = '0;
    end
  end

  assign push_o     = accept && has_res;
  assign push_cmd_o = cmd;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      acc_q   <= '0;
      dcnt_q  <= '0;
      hi_q    <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      dcnt_q  <= dcnt_d;
      hi_q    <= hi_d;
    end
  end

endmodule

// ===== hw/rtl/jsu_queue.sv =====
module jsu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output jsu_pkg::cmd_t head_o
);
  import jsu_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // command storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/jsu_back.sv =====
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  jsu_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [1:0]    result_kind_o,
  output logic [7:0]    out_byte_o,
  output logic [3:0]    error_code_o,
  output logic          last_of_run_o
);
  import jsu_pkg::*;

  logic       valid_q;
  logic [1:0] idx_q;
  logic [1:0] kind_q;
  logic [7:0] byte_q;
  logic [3:0] code_q;
  logic       last_q;
  logic       load;
  logic       is_last;

  // output register takes a new result when empty or being taken
  assign load    = !empty_i && (!valid_q || !out_stall_i);
  assign is_last = (idx_q == head_i.cnt);
  assign pop_o   = load && is_last;

  // result index within the head command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= head_i.kind;
      byte_q <= head_i.bytes[idx_q];
      code_q <= head_i.code;
      last_q <= is_last;
    end
  end

  assign out_valid_o   = valid_q;
  assign result_kind_o = kind_q;
  assign out_byte_o    = byte_q;
  assign error_code_o  = code_q;
  assign last_of_run_o = last_q;

endmodule

// ===== hw/rtl/json_string_unescape_utf8.sv =====
// Streaming JSON string unescaper. Feed the bytes of one quoted string token,
// opening quote first, one byte per transaction (req_type_i = 1 marks end of
// text). The block accepts one byte per cycle while the queue is not full; each
// byte yields zero to four results (decoded bytes, a done mark or an error),
// delivered on the output channel one per cycle while out_stall_i is low, with
// last_of_run_o on the final result of that byte. A four-entry command queue
// between decoder and output serializer absorbs multi-byte UTF-8 output;
// in_stall_o rises only while that queue is full, so sustained input rate is one
// byte per cycle while the average result count stays at one and out_stall_i
// stays low. A byte's first result passes the queue and the output register.
// After done or any error the block waits for a new opening quote.
module json_string_unescape_utf8 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] result_kind_o,
  output logic [7:0] out_byte_o,
  output logic [3:0] error_code_o,
  output logic       last_of_run_o
);
  import jsu_pkg::*;

  logic q_full, q_empty, push, pop;
  cmd_t push_cmd, head;

  // decoder and phase tracking
  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_cmd_o  (push_cmd)
  );

  // command queue
  jsu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head)
  );

  // result serializer
  jsu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .out_byte_o    (out_byte_o),
    .error_code_o  (error_code_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
